/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SFR_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SFR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and fixed widths of the stereo frame ring.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int CNT_W      = 13;   // capacity and fill count width
	localparam int SAMPLE_W   = 32;   // sample port width
	localparam int OVR_W      = 32;   // overrun counter width
	localparam int MIN_FRAMES = 256;  // smallest usable ring depth
	localparam int CHANNELS   = 2;    // left and right

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_READ  = 1'b1
	} mode_t;

endpackage

/* rtl/core/sfr_ram.sv */
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/stereo_frame_ring_drop_oldest.sv */
// ----------------------------------------------------------------------------
// stereo_frame_ring_drop_oldest
// Circular buffer of stereo frames that drops the oldest frame on overflow.
// ----------------------------------------------------------------------------
// A result is registered and appears in the cycle after its item is transferred in.
// Throughput: one item per cycle while the result register drains; the frame
//   RAM read fits under the result register, so reads pipeline.
// Reset: pointers, fill count, overrun state and result valid clear at once;
//   capacity returns to 256. Frame RAM contents are not cleared.
module stereo_frame_ring_drop_oldest #(
	parameter int DEPTH       = 4096,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item input channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [sfr_pkg::SAMPLE_W-1:0] left_sample,
	input  logic [sfr_pkg::SAMPLE_W-1:0] right_sample,
	input  logic                        burst_first,
	// result output channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        frame_valid,
	output logic [sfr_pkg::SAMPLE_W-1:0] left_out,
	output logic [sfr_pkg::SAMPLE_W-1:0] right_out,
	output logic [sfr_pkg::CNT_W-1:0]    frames_stored,
	output logic [sfr_pkg::OVR_W-1:0]    overrun_total,
	// capacity register write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sfr_pkg::CNT_W-1:0]    cfg_data
);

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int FRAME_W = sfr_pkg::CHANNELS * SAMPLE_BITS;
	// wide enough for pointer + count before the wrap subtract
	localparam int ARITH_W = ((PTR_W > sfr_pkg::CNT_W) ? PTR_W : sfr_pkg::CNT_W) + 1;
	// room to compare a capacity write against DEPTH without overflow
	localparam int CMP_W   = ((PTR_W + 1) > sfr_pkg::CNT_W) ? (PTR_W + 1) : sfr_pkg::CNT_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
	localparam logic [CMP_W-1:0] MIN_C   = CMP_W'(sfr_pkg::MIN_FRAMES);

	// ring state
	logic [sfr_pkg::CNT_W-1:0] capacity_q, capacity_d;
	logic [PTR_W-1:0]          rd_ptr_q, rd_ptr_d;
	logic [sfr_pkg::CNT_W-1:0] fill_q, fill_d;
	logic [sfr_pkg::OVR_W-1:0] overrun_q, overrun_d;
	logic                      dropped_q, dropped_d;

	// result register
	logic                      out_valid_q;
	logic                      frame_valid_q;
	logic                      pop_q;
	logic [sfr_pkg::CNT_W-1:0] frames_q;
	logic [sfr_pkg::OVR_W-1:0] overrun_out_q;

	// RAM interface
	logic                      ram_we, ram_re;
	logic [PTR_W-1:0]          ram_waddr;
	logic [FRAME_W-1:0]        ram_wdata, ram_rdata;

	logic                      in_xfer, cfg_xfer;
	logic                      is_read, full, empty;
	logic [ARITH_W-1:0]        cap_a, rp_inc, wp_sum, rp_adv;
	logic [sfr_pkg::CNT_W-1:0] fill_mid;
	logic [CMP_W-1:0]          cfg_ext, cfg_sat;

	// Take a new item whenever the result slot is empty or is being drained.
	assign in_stall  = out_valid_q && out_stall;
	assign in_xfer   = in_valid && !in_stall;
	// Capacity writes must arrive only while idle (the block does not enforce it); always take them.
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	// Saturate a capacity write to the range MIN_FRAMES..DEPTH.
	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext < MIN_C) begin
			cfg_sat = MIN_C;
		end else if (cfg_ext > DEPTH_C) begin
			cfg_sat = DEPTH_C;
		end else begin
			cfg_sat = cfg_ext;
		end
	end

	assign is_read = (sfr_pkg::mode_t'(mode) == sfr_pkg::MODE_READ);
	assign cap_a   = ARITH_W'(capacity_q);
	assign full    = (fill_q >= capacity_q);
	assign empty   = (fill_q == '0);

	// Advance the read pointer by one, wrapping at the capacity.
	always_comb begin
		rp_inc = ARITH_W'(rd_ptr_q) + ARITH_W'(1);
		if (rp_inc >= cap_a) begin
			rp_inc = rp_inc - cap_a;
		end
	end

	// Next ring state and RAM requests for the transferred item.
	always_comb begin
		capacity_d = capacity_q;
		rd_ptr_d   = rd_ptr_q;
		fill_d     = fill_q;
		overrun_d  = overrun_q;
		dropped_d  = dropped_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		fill_mid   = fill_q;
		rp_adv     = ARITH_W'(rd_ptr_q);
		wp_sum     = '0;

		if (cfg_xfer) begin
			// A capacity write empties the ring and clears overrun history.
			capacity_d = sfr_pkg::CNT_W'(cfg_sat);
			rd_ptr_d   = '0;
			fill_d     = '0;
			overrun_d  = '0;
			dropped_d  = 1'b0;
		end else if (in_xfer && !is_read) begin
			if (burst_first) begin
				dropped_d = 1'b0;
			end
			if (full) begin
				// Drop the oldest frame; count the overrun once per burst.
				rp_adv   = rp_inc;
				fill_mid = capacity_q - sfr_pkg::CNT_W'(1);
				if (!dropped_d) begin
					overrun_d = overrun_q + sfr_pkg::OVR_W'(1);
					dropped_d = 1'b1;
				end
			end
			wp_sum = rp_adv + ARITH_W'(fill_mid);
			if (wp_sum >= cap_a) begin
				wp_sum = wp_sum - cap_a;
			end
			rd_ptr_d = PTR_W'(rp_adv);
			fill_d   = fill_mid + sfr_pkg::CNT_W'(1);
			ram_we   = 1'b1;
		end else if (in_xfer && !empty) begin
			// Pop: the RAM delivers the frame with the result next cycle.
			ram_re   = 1'b1;
			rd_ptr_d = PTR_W'(rp_inc);
			fill_d   = fill_q - sfr_pkg::CNT_W'(1);
		end
	end

	assign ram_waddr = PTR_W'(wp_sum);
	assign ram_wdata = {left_sample[SAMPLE_BITS-1:0], right_sample[SAMPLE_BITS-1:0]};

	sfr_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= sfr_pkg::CNT_W'(sfr_pkg::MIN_FRAMES);
			rd_ptr_q   <= '0;
			fill_q     <= '0;
			overrun_q  <= '0;
			dropped_q  <= 1'b0;
		end else begin
			capacity_q <= capacity_d;
			rd_ptr_q   <= rd_ptr_d;
			fill_q     <= fill_d;
			overrun_q  <= overrun_d;
			dropped_q  <= dropped_d;
		end
	end

	// Result register: load on an input transfer without a capacity write, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && !cfg_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && !cfg_xfer) begin
			frame_valid_q <= !is_read || !empty;
			pop_q         <= is_read && !empty;
			frames_q      <= fill_d;
			overrun_out_q <= overrun_d;
		end
	end

	// RAM read data holds until the next pop, which waits for this slot.
	assign out_valid     = out_valid_q;
	assign frame_valid   = frame_valid_q;
	assign left_out      = pop_q ? sfr_pkg::SAMPLE_W'(ram_rdata[FRAME_W-1:SAMPLE_BITS]) : '0;
	assign right_out     = pop_q ? sfr_pkg::SAMPLE_W'(ram_rdata[SAMPLE_BITS-1:0]) : '0;
	assign frames_stored = frames_q;
	assign overrun_total = overrun_out_q;

endmodule

/* rtl/core/sfr_checker.sv */
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the stereo frame ring, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_checker #(
	parameter int DEPTH = 4096
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         mode,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         frame_valid,
	input logic [sfr_pkg::SAMPLE_W-1:0] left_out,
	input logic [sfr_pkg::SAMPLE_W-1:0] right_out,
	input logic [sfr_pkg::CNT_W-1:0]    frames_stored
);

	logic in_xfer;
	logic wr_xfer;
	logic wr_result_ok;
	logic empty_read;
	logic data_zero;

	assign in_xfer      = in_valid && !in_stall;
	assign wr_xfer      = in_xfer && (sfr_pkg::mode_t'(mode) == sfr_pkg::MODE_WRITE);
	assign wr_result_ok = out_valid && frame_valid && (frames_stored != '0);
	assign empty_read   = out_valid && !frame_valid;
	assign data_zero    = (left_out == '0) && (right_out == '0);

	`SFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")
	`SFR_ASSERT_NEXT(a_write_result, clk, arst_n, wr_xfer, wr_result_ok, "write gave no result")
	`SFR_ASSERT_IMPL(a_empty_zero, clk, arst_n, empty_read, data_zero, "empty read returned data")
	`SFR_ASSERT_IMPL(a_fill_bound, clk, arst_n, out_valid, frames_stored <= DEPTH, "fill above depth")

endmodule

bind stereo_frame_ring_drop_oldest sfr_checker #(
	.DEPTH (DEPTH)
) u_sfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.mode          (mode),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.frame_valid   (frame_valid),
	.left_out      (left_out),
	.right_out     (right_out),
	.frames_stored (frames_stored)
);

/* test/tb_stereo_frame_ring_drop_oldest.sv */
// ----------------------------------------------------------------------------
// tb_stereo_frame_ring_drop_oldest
// Self-checking bench for the stereo frame ring with drop-oldest overflow.
// A directed table walks through the empty-read, fill, drop and burst cases.
// After it come random write/read traffic that alternates between filling
// and draining at several ring capacities, and a short run at the largest
// capacity. Every result transfer is compared against a hand-typed result or
// a behavioral ring kept in the bench.
// ----------------------------------------------------------------------------
module tb_stereo_frame_ring_drop_oldest;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	localparam int RING_DEPTH  = 4096;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 400;

	// One input item and one result, at the port widths.
	typedef struct packed {
		mode_t             mode;
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic              burst_first;
	} frame_item_t;

	typedef struct packed {
		logic              frame_valid;
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic [CNT_W-1:0]  stored;
		logic [OVR_W-1:0]  overrun;
	} frame_result_t;

	// Directed row: the item, how often to repeat it, and, for rows whose
	// outcome is obvious, the result typed in by hand.
	typedef struct packed {
		mode_t             mode;
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic              burst_first;
		logic [CNT_W-1:0]  reps;
		logic              typed;
		logic              exp_valid;
		logic [SAMPLE_W-1:0] exp_left;
		logic [SAMPLE_W-1:0] exp_right;
		logic [CNT_W-1:0]  exp_stored;
		logic [OVR_W-1:0]  exp_overrun;
	} dir_row_t;

	// Capacity is 256 after reset. Repeated rows bump the left sample and
	// xor the right one with the repeat index so every frame is distinct.
	localparam dir_row_t DIRECTED [18] = '{
		// read on an empty ring: nothing popped, ignored fields all ones
		'{MODE_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 13'd1, 1'b1,
			1'b0, 32'h0, 32'h0, 13'd0, 32'd0},
		// writes before any burst start, then extremes of the samples
		'{MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd1, 32'd0},
		'{MODE_WRITE, 32'h0000_0000, 32'h0000_0000, 1'b1, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd2, 32'd0},
		'{MODE_WRITE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd3, 32'd0},
		// pop them back in order, then read empty again
		'{MODE_READ,  32'h0000_0000, 32'h0000_0000, 1'b0, 13'd1, 1'b1,
			1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd2, 32'd0},
		'{MODE_READ,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd1, 32'd0},
		'{MODE_READ,  32'h0000_0000, 32'h0000_0000, 1'b0, 13'd1, 1'b1,
			1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 13'd0, 32'd0},
		'{MODE_READ,  32'h0000_0000, 32'h0000_0000, 1'b0, 13'd1, 1'b1,
			1'b0, 32'h0, 32'h0, 13'd0, 32'd0},
		// fill the ring to capacity
		'{MODE_WRITE, 32'h1234_0000, 32'h0000_ABCD, 1'b0, 13'd256, 1'b0,
			1'b0, 32'h0, 32'h0, 13'd0, 32'd0},
		// write when full: first drop of the burst counts, the next does not
		'{MODE_WRITE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd256, 32'd1},
		'{MODE_WRITE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd256, 32'd1},
		// new burst while full counts again
		'{MODE_WRITE, 32'hDEAD_0001, 32'hBEEF_0001, 1'b1, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd256, 32'd2},
		'{MODE_WRITE, 32'hDEAD_0002, 32'hBEEF_0002, 1'b0, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd256, 32'd2},
		// oldest survivor after the drops
		'{MODE_READ,  32'h0000_0000, 32'h0000_0000, 1'b0, 13'd1, 1'b0,
			1'b0, 32'h0, 32'h0, 13'd0, 32'd0},
		// burst start without a drop, then a drop inside that burst
		'{MODE_WRITE, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd256, 32'd2},
		'{MODE_WRITE, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b0, 13'd1, 1'b1,
			1'b1, 32'h0, 32'h0, 13'd256, 32'd3},
		// drain across the wrap of the read pointer
		'{MODE_READ,  32'h0000_0000, 32'h0000_0000, 1'b0, 13'd256, 1'b0,
			1'b0, 32'h0, 32'h0, 13'd0, 32'd0},
		'{MODE_READ,  32'h0000_0000, 32'h0000_0000, 1'b1, 13'd1, 1'b1,
			1'b0, 32'h0, 32'h0, 13'd0, 32'd3}
	};

	logic clk = 1'b0;
	logic arst_n;

	logic                in_valid;
	logic                in_stall;
	logic                mode;
	logic [SAMPLE_W-1:0] left_sample;
	logic [SAMPLE_W-1:0] right_sample;
	logic                burst_first;
	logic                out_valid;
	logic                out_stall;
	logic                frame_valid;
	logic [SAMPLE_W-1:0] left_out;
	logic [SAMPLE_W-1:0] right_out;
	logic [CNT_W-1:0]    frames_stored;
	logic [OVR_W-1:0]    overrun_total;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data;

	always #4 clk = ~clk;

	stereo_frame_ring_drop_oldest u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.burst_first   (burst_first),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_valid   (frame_valid),
		.left_out      (left_out),
		.right_out     (right_out),
		.frames_stored (frames_stored),
		.overrun_total (overrun_total),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Behavioral ring: its own copy of the frames, pointers and counters.
	// ------------------------------------------------------------------------
	logic [2*SAMPLE_W-1:0] ring_frames [RING_DEPTH];
	int                    ring_head      = 0;
	int                    ring_fill      = 0;
	int                    ring_capacity  = MIN_FRAMES;
	logic [OVR_W-1:0]      ring_overruns  = '0;
	bit                    ring_burst_hit = 1'b0;

	frame_result_t expected_results [$];

	int  errors         = 0;
	int  cycle_count    = 0;
	int  frames_written = 0;
	int  frames_read    = 0;
	int  empty_reads    = 0;
	int  drop_bursts    = 0;
	int  capacity_count = 1;
	int  burst_left     = 0;
	bit  hold_request   = 1'b0;

	function automatic int ring_wrap(int pos);
		return (pos >= ring_capacity) ? pos - ring_capacity : pos;
	endfunction

	// Saturate the requested depth and empty the ring.
	function automatic void ring_set_capacity(logic [CNT_W-1:0] word);
		int depth;
		depth = int'(word);
		if (depth < MIN_FRAMES)
			depth = MIN_FRAMES;
		if (depth > RING_DEPTH)
			depth = RING_DEPTH;
		ring_capacity  = depth;
		ring_head      = 0;
		ring_fill      = 0;
		ring_overruns  = '0;
		ring_burst_hit = 1'b0;
		capacity_count++;
	endfunction

	// Apply one item to the ring and return the result it produces.
	function automatic frame_result_t ring_apply(frame_item_t item);
		frame_result_t res;
		logic [2*SAMPLE_W-1:0] popped;
		res = '0;
		res.frame_valid = 1'b1;
		if (item.mode == MODE_WRITE) begin
			frames_written++;
			if (item.burst_first)
				ring_burst_hit = 1'b0;
			// full: step past the oldest frame, count once per burst
			if (ring_fill >= ring_capacity) begin
				ring_head = ring_wrap(ring_head + 1);
				ring_fill = ring_capacity - 1;
				if (!ring_burst_hit) begin
					ring_overruns++;
					ring_burst_hit = 1'b1;
					drop_bursts++;
				end
			end
			ring_frames[ring_wrap(ring_head + ring_fill)] = {item.left, item.right};
			ring_fill++;
		end else if (ring_fill == 0) begin
			empty_reads++;
			res.frame_valid = 1'b0;
		end else begin
			frames_read++;
			popped    = ring_frames[ring_head];
			res.left  = popped[2*SAMPLE_W-1:SAMPLE_W];
			res.right = popped[SAMPLE_W-1:0];
			ring_head = ring_wrap(ring_head + 1);
			ring_fill--;
		end
		res.stored  = CNT_W'(ring_fill);
		res.overrun = ring_overruns;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Sender side. Inputs change only at the falling edge; a transfer is
	// seen at the rising edge where in_valid is high and in_stall is low.
	// ------------------------------------------------------------------------
	task automatic offer(frame_item_t item, bit typed, frame_result_t typed_result);
		frame_result_t predicted;
		int gap;
		// start a new burst after a random gap, sometimes a long run
		// with no gap at all
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 24);
		end
		burst_left--;
		in_valid     <= 1'b1;
		mode         <= item.mode;
		left_sample  <= item.left;
		right_sample <= item.right;
		burst_first  <= item.burst_first;
		// hold the payload until the block takes it
		do @(posedge clk); while (in_stall);
		predicted = ring_apply(item);
		expected_results.push_back(typed ? typed_result : predicted);
		@(negedge clk);
	endtask

	// Random traffic: write_pct percent writes, short bursts of writes.
	task automatic random_segment(int write_pct, int count);
		frame_item_t item;
		frame_result_t unused;
		unused = '0;
		repeat (count) begin
			item.mode        = ($urandom_range(1, 100) <= write_pct) ? MODE_WRITE : MODE_READ;
			item.left        = $urandom;
			item.right       = $urandom;
			item.burst_first = ($urandom_range(0, 5) == 0);
			offer(item, 1'b0, unused);
		end
	endtask

	// Write the capacity register once the block has drained.
	task automatic set_capacity(logic [CNT_W-1:0] word);
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
		ring_set_capacity(word);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Alternate fill-heavy and drain-heavy stretches so the ring moves
	// toward both the full and the empty end at this capacity.
	task automatic capacity_phase(logic [CNT_W-1:0] word, int count);
		int done;
		int seg;
		int len;
		done = 0;
		seg  = 0;
		set_capacity(word);
		while (done < count) begin
			len = $urandom_range(40, 300);
			if (len > count - done)
				len = count - done;
			if (seg % 2 == 0)
				random_segment($urandom_range(70, 100), len);
			else
				random_segment($urandom_range(0, 45), len);
			done += len;
			seg++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		frame_item_t   item;
		frame_result_t typed_result;
		int            row;
		int            rep;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		mode         <= MODE_WRITE;
		left_sample  <= '0;
		right_sample <= '0;
		burst_first  <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table at the reset capacity
		for (row = 0; row < $size(DIRECTED); row++) begin
			for (rep = 0; rep < int'(DIRECTED[row].reps); rep++) begin
				item.mode                = DIRECTED[row].mode;
				item.left                = DIRECTED[row].left + SAMPLE_W'(rep);
				item.right               = DIRECTED[row].right ^ SAMPLE_W'(rep);
				item.burst_first         = DIRECTED[row].burst_first;
				typed_result.frame_valid = DIRECTED[row].exp_valid;
				typed_result.left        = DIRECTED[row].exp_left;
				typed_result.right       = DIRECTED[row].exp_right;
				typed_result.stored      = DIRECTED[row].exp_stored;
				typed_result.overrun     = DIRECTED[row].exp_overrun;
				offer(item, DIRECTED[row].typed, typed_result);
			end
		end

		// zero saturates up to the smallest depth; ask the receiver for a
		// long hold-off so the block backs up and stalls its input
		hold_request = 1'b1;
		capacity_phase(13'd0, 400);
		capacity_phase(13'd257, 300);
		capacity_phase(13'($urandom_range(256, 400)), 300);
		capacity_phase(13'd1, 300);

		// all ones saturates down to the full depth: a short fill-heavy
		// run, then mixed traffic
		set_capacity(13'h1FFF);
		random_segment(100, 70);
		random_segment(40, 50);

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Covered %0d writes and %0d reads (%0d on an empty ring),",
			frames_written, frames_read + empty_reads, empty_reads);
		$display("%0d overrun bursts over %0d capacity settings.",
			drop_bursts, capacity_count);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver stall pattern: random styles for random spans, plus one long
	// hold-off on request.
	// ------------------------------------------------------------------------
	initial begin : receiver_stall
		int style;
		int span;
		out_stall <= 1'b0;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				repeat (LONG_HOLD) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			style = $urandom_range(0, 4);
			span  = $urandom_range(16, 160);
			repeat (span) begin
				@(negedge clk);
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 4) == 0);
					2: out_stall <= $urandom_range(0, 1);
					3: out_stall <= ($urandom_range(0, 4) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------
	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result transfer, expected none, got %h %h %h %0d %0d",
					$realtime, frame_valid, left_out, right_out, frames_stored, overrun_total);
			end else begin
				want = expected_results.pop_front();
				check_field("frame_valid", 32'(want.frame_valid), 32'(frame_valid));
				check_field("left_out", want.left, left_out);
				check_field("right_out", want.right, right_out);
				check_field("frames_stored", 32'(want.stored), 32'(frames_stored));
				check_field("overrun_total", want.overrun, overrun_total);
			end
		end
	end

	// Give up well past the slowest legal run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
